// ===== rtl/core/rdi_pkg.sv =====
`default_nettype none

package rdi_pkg;

    // default build options
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // fixed field widths
    localparam int POS_W   = 32;
    localparam int T_W     = 31;
    localparam int UV_BITS = 16;
    localparam int V_W     = UV_BITS + 1;

    localparam logic [T_W-1:0] RADIUS_RESET = T_W'(65536);
    localparam logic [V_W-1:0] V_ONE        = V_W'(1) << UV_BITS;

    // angle in turns, Q0.32
    localparam int          ANGLE_W   = 32;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam int          ATAN_LEN  = 24;

    // floor(atan(2^-i) / (2 pi) * 2^32)
    localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic signed [POS_W-1:0] origin_z;
        logic signed [POS_W-1:0] dir_x;
        logic signed [POS_W-1:0] dir_y;
        logic signed [POS_W-1:0] dir_z;
        logic        [T_W-1:0]   t_limit;
    } t_ray;

    typedef struct packed {
        logic                    hit;
        logic        [T_W-1:0]   t_hit;
        logic signed [POS_W-1:0] hit_x;
        logic signed [POS_W-1:0] hit_z;
        logic        [UV_BITS-1:0] coord_u;
        logic        [V_W-1:0]   coord_v;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/rdi_if.sv =====
`default_nettype none

// ray request channel
interface rdi_ray_if;
    import rdi_pkg::*;
    logic valid;
    logic ready;
    t_ray data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface rdi_res_if;
    import rdi_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// radius write channel
interface rdi_cfg_if;
    import rdi_pkg::*;
    logic           valid;
    logic           ready;
    logic [T_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rdi_div_pipe.sv =====
`default_nettype none

// Restoring divider, one quotient bit per stage. The caller guarantees
// (num >> QUO_W) < den, or discards the result.
module rdi_div_pipe #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 31,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [QUO_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int RW = DEN_W + 1;

    logic              r_valid [QUO_W];
    logic [RW-1:0]     r_rem   [QUO_W];
    logic [QUO_W-1:0]  r_quo   [QUO_W];
    logic [QUO_W-1:0]  r_low   [QUO_W];
    logic [DEN_W-1:0]  r_den   [QUO_W];
    logic [SIDE_W-1:0] r_side  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              p_valid;
        logic [RW-1:0]     p_rem;
        logic [QUO_W-1:0]  p_quo;
        logic [QUO_W-1:0]  p_low;
        logic [DEN_W-1:0]  p_den;
        logic [SIDE_W-1:0] p_side;
        logic [RW-1:0]     trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = RW'(i_num >> QUO_W);
            assign p_quo   = '0;
            assign p_low   = i_num[QUO_W-1:0];
            assign p_den   = i_den;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[k-1];
            assign p_rem   = r_rem[k-1];
            assign p_quo   = r_quo[k-1];
            assign p_low   = r_low[k-1];
            assign p_den   = r_den[k-1];
            assign p_side  = r_side[k-1];
        end

        // bring down the next dividend bit and try the subtraction
        assign trial = {p_rem[RW-2:0], p_low[QUO_W-1-k]};
        assign ge    = (trial >= {1'b0, p_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (trial - {1'b0, p_den}) : trial;
                r_quo[k]  <= {p_quo[QUO_W-2:0], ge};
                r_low[k]  <= p_low;
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/rdi_cordic_pipe.sv =====
`default_nettype none

// CORDIC vectoring, one micro-rotation per stage, angle in turns (Q0.32).
module rdi_cordic_pipe #(
    parameter int STEPS  = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic signed [rdi_pkg::POS_W-1:0] i_x,
    input  wire logic signed [rdi_pkg::POS_W-1:0] i_y,
    input  wire logic [SIDE_W-1:0]           i_side,
    output logic                             o_valid,
    output logic [rdi_pkg::ANGLE_W-1:0]      o_angle,
    output logic [SIDE_W-1:0]                o_side
);

    import rdi_pkg::*;

    // headroom for the CORDIC gain
    localparam int CW = POS_W + 3;

    logic                r_valid [STEPS+1];
    logic signed [CW-1:0] r_x    [STEPS+1];
    logic signed [CW-1:0] r_y    [STEPS+1];
    logic [ANGLE_W-1:0]  r_a     [STEPS+1];
    logic [SIDE_W-1:0]   r_side  [STEPS+1];

    logic signed [CW-1:0] x_ext;
    logic signed [CW-1:0] y_ext;

    assign x_ext = CW'(i_x);
    assign y_ext = CW'(i_y);

    // left half-plane: rotate by half a turn first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= i_x[POS_W-1] ? -x_ext : x_ext;
            r_y[0]    <= i_x[POS_W-1] ? -y_ext : y_ext;
            r_a[0]    <= i_x[POS_W-1] ? HALF_TURN : '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic                 neg;

        assign sx  = r_y[k] >>> k;
        assign sy  = r_x[k] >>> k;
        assign neg = r_y[k][CW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!neg) begin
                    r_x[k+1] <= r_x[k] + sx;
                    r_y[k+1] <= r_y[k] - sy;
                    r_a[k+1] <= r_a[k] + ATAN_TURNS[k];
                end else begin
                    r_x[k+1] <= r_x[k] - sx;
                    r_y[k+1] <= r_y[k] + sy;
                    r_a[k+1] <= r_a[k] - ATAN_TURNS[k];
                end
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_valid[STEPS];
    assign o_angle = r_a[STEPS];
    assign o_side  = r_side[STEPS];

endmodule

`default_nettype wire

// ===== rtl/core/ray_disk_intersect_unit.sv =====
// Pipeline, in order: t divider, hit point and range checks, CORDIC,
//   square root, radial divider, output register.
// Throughput: one ray per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active low; empties the pipeline, radius back to 1.0.
`default_nettype none

module ray_disk_intersect_unit #(
    parameter int FRAC_BITS    = rdi_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = rdi_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rdi_ray_if.sink    i_ray,
    rdi_cfg_if.sink    i_cfg,
    rdi_res_if.source  o_res
);

    import rdi_pkg::*;

    localparam int NUM_T_W = POS_W + FRAC_BITS;
    localparam int XW      = 65 - FRAC_BITS;
    localparam int SQ_STEPS = 32;
    localparam int RAD_W   = 2 * SQ_STEPS;
    localparam int SREM_W  = SQ_STEPS + 3;
    localparam int VNUM_W  = T_W + UV_BITS;

    typedef struct packed {
        logic signed [POS_W-1:0] ox;
        logic signed [POS_W-1:0] oz;
        logic signed [POS_W-1:0] dx;
        logic signed [POS_W-1:0] dz;
        logic        [T_W-1:0]   tlim;
        logic                    ok;
    } t_tside;

    typedef struct packed {
        logic                    hit;
        logic        [T_W-1:0]   t;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] z;
        logic        [2*T_W:0]   dist2;
        logic                    centre;
    } t_cside;

    typedef struct packed {
        logic                    hit;
        logic        [T_W-1:0]   t;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] z;
        logic        [UV_BITS-1:0] u;
    } t_qside;

    logic en;
    logic r_out_valid;
    t_result r_out;
    logic [T_W-1:0] r_radius;

    // whole pipeline advances unless the result register is held
    assign en          = !r_out_valid || o_res.ready;
    assign i_ray.ready = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg.valid) begin
            r_radius <= i_cfg.data;
        end
    end

    // ---- t = -oy / dy on magnitudes ----
    logic [POS_W-1:0]   oy_mag;
    logic [POS_W-1:0]   dy_mag;
    logic [NUM_T_W-1:0] t_num;
    logic               t_ovf;
    t_tside             t_in_side;
    logic               d_valid;
    logic [T_W-1:0]     d_t;
    t_tside             d_side;

    assign oy_mag = i_ray.data.origin_y[POS_W-1] ? POS_W'(-i_ray.data.origin_y)
                                                 : POS_W'(i_ray.data.origin_y);
    assign dy_mag = i_ray.data.dir_y[POS_W-1] ? POS_W'(-i_ray.data.dir_y)
                                              : POS_W'(i_ray.data.dir_y);
    assign t_num  = {oy_mag, {FRAC_BITS{1'b0}}};
    // quotient of 2^31 or more can never be below the limit
    assign t_ovf  = (NUM_T_W'(t_num >> T_W) >= NUM_T_W'(dy_mag));

    always_comb begin
        t_in_side.ox   = i_ray.data.origin_x;
        t_in_side.oz   = i_ray.data.origin_z;
        t_in_side.dx   = i_ray.data.dir_x;
        t_in_side.dz   = i_ray.data.dir_z;
        t_in_side.tlim = i_ray.data.t_limit;
        // positive t needs opposite signs and neither zero
        t_in_side.ok   = (i_ray.data.origin_y != '0) && (i_ray.data.dir_y != '0)
                      && (i_ray.data.origin_y[POS_W-1] != i_ray.data.dir_y[POS_W-1])
                      && !t_ovf;
    end

    rdi_div_pipe #(
        .NUM_W  (NUM_T_W),
        .DEN_W  (POS_W),
        .QUO_W  (T_W),
        .SIDE_W ($bits(t_tside))
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_ray.valid),
        .i_num   (t_num),
        .i_den   (dy_mag),
        .i_side  (t_in_side),
        .o_valid (d_valid),
        .o_quo   (d_t),
        .o_side  (d_side)
    );

    // ---- stage 2: range check on t, products d*t ----
    logic                    r2_v;
    logic                    r2_ok;
    logic        [T_W-1:0]   r2_t;
    logic signed [POS_W-1:0] r2_ox;
    logic signed [POS_W-1:0] r2_oz;
    logic signed [63:0]      r2_px;
    logic signed [63:0]      r2_pz;
    logic signed [POS_W-1:0] d_ts;

    assign d_ts = signed'({1'b0, d_t});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ok <= d_side.ok && (d_t != '0) && (d_t < d_side.tlim);
            r2_t  <= d_t;
            r2_ox <= d_side.ox;
            r2_oz <= d_side.oz;
            r2_px <= d_side.dx * d_ts;
            r2_pz <= d_side.dz * d_ts;
        end
    end

    // ---- stage 3: hit point ----
    logic                 r3_v;
    logic                 r3_ok;
    logic [T_W-1:0]       r3_t;
    logic signed [XW-1:0] r3_x;
    logic signed [XW-1:0] r3_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ok <= r2_ok;
            r3_t  <= r2_t;
            r3_x  <= XW'(64'(r2_ox) + (r2_px >>> FRAC_BITS));
            r3_z  <= XW'(64'(r2_oz) + (r2_pz >>> FRAC_BITS));
        end
    end

    // ---- stage 4: box test against the radius ----
    logic [XW-1:0]           s3_ax;
    logic [XW-1:0]           s3_az;
    logic                    r4_v;
    logic                    r4_ok;
    logic [T_W-1:0]          r4_t;
    logic signed [POS_W-1:0] r4_x;
    logic signed [POS_W-1:0] r4_z;
    logic [T_W-1:0]          r4_ax;
    logic [T_W-1:0]          r4_az;

    assign s3_ax = r3_x[XW-1] ? XW'(-r3_x) : XW'(r3_x);
    assign s3_az = r3_z[XW-1] ? XW'(-r3_z) : XW'(r3_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ok <= r3_ok && (s3_ax <= XW'(r_radius)) && (s3_az <= XW'(r_radius));
            r4_t  <= r3_t;
            r4_x  <= r3_x[POS_W-1:0];
            r4_z  <= r3_z[POS_W-1:0];
            r4_ax <= s3_ax[T_W-1:0];
            r4_az <= s3_az[T_W-1:0];
        end
    end

    // ---- stage 5: squares ----
    logic                    r5_v;
    logic                    r5_ok;
    logic [T_W-1:0]          r5_t;
    logic signed [POS_W-1:0] r5_x;
    logic signed [POS_W-1:0] r5_z;
    logic [2*T_W-1:0]        r5_sx;
    logic [2*T_W-1:0]        r5_sz;
    logic [2*T_W-1:0]        r5_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ok <= r4_ok;
            r5_t  <= r4_t;
            r5_x  <= r4_x;
            r5_z  <= r4_z;
            r5_sx <= r4_ax * r4_ax;
            r5_sz <= r4_az * r4_az;
            r5_rr <= r_radius * r_radius;
        end
    end

    // ---- stage 6: distance test ----
    logic [2*T_W:0] s5_dist2;
    logic           r6_v;
    t_cside         r6_side;

    assign s5_dist2 = (2*T_W+1)'(r5_sx) + (2*T_W+1)'(r5_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side.hit    <= r5_ok && (s5_dist2 <= (2*T_W+1)'(r5_rr));
            r6_side.t      <= r5_t;
            r6_side.x      <= r5_x;
            r6_side.z      <= r5_z;
            r6_side.dist2  <= s5_dist2;
            r6_side.centre <= (r5_x == '0) && (r5_z == '0);
        end
    end

    // ---- angle of (x, -z) ----
    logic               c_valid;
    logic [ANGLE_W-1:0] c_angle;
    t_cside             c_side;
    logic signed [POS_W-1:0] r6_nz;

    assign r6_nz = -r6_side.z;

    rdi_cordic_pipe #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W ($bits(t_cside))
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_x     (r6_side.x),
        .i_y     (r6_nz),
        .i_side  (r6_side),
        .o_valid (c_valid),
        .o_angle (c_angle),
        .o_side  (c_side)
    );

    // ---- integer square root, two radicand bits per stage ----
    logic              r_sq_v    [SQ_STEPS];
    logic [SREM_W-1:0] r_sq_rem  [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_sq_root [SQ_STEPS];
    logic [RAD_W-1:0]  r_sq_rad  [SQ_STEPS];
    t_qside            r_sq_side [SQ_STEPS];
    t_qside            q_in_side;

    always_comb begin
        q_in_side.hit = c_side.hit;
        q_in_side.t   = c_side.t;
        q_in_side.x   = c_side.x;
        q_in_side.z   = c_side.z;
        q_in_side.u   = c_side.centre ? '0 : c_angle[ANGLE_W-1 -: UV_BITS];
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic                p_v;
        logic [SREM_W-1:0]   p_rem;
        logic [SQ_STEPS-1:0] p_root;
        logic [RAD_W-1:0]    p_rad;
        t_qside              p_side;
        logic [SREM_W-1:0]   trial;
        logic [SREM_W-1:0]   test;
        logic                ge;

        if (k == 0) begin : g_first
            assign p_v    = c_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = RAD_W'(c_side.dist2);
            assign p_side = q_in_side;
        end else begin : g_next
            assign p_v    = r_sq_v[k-1];
            assign p_rem  = r_sq_rem[k-1];
            assign p_root = r_sq_root[k-1];
            assign p_rad  = r_sq_rad[k-1];
            assign p_side = r_sq_side[k-1];
        end

        assign trial = {p_rem[SREM_W-3:0], p_rad[RAD_W-1-2*k -: 2]};
        assign test  = SREM_W'({p_root, 2'b01});
        assign ge    = (trial >= test);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (en) begin
                r_sq_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k]  <= ge ? (trial - test) : trial;
                r_sq_root[k] <= {p_root[SQ_STEPS-2:0], ge};
                r_sq_rad[k]  <= p_rad;
                r_sq_side[k] <= p_side;
            end
        end
    end

    // ---- v = rHit / radius ----
    logic [VNUM_W-1:0] v_num;
    logic              v_valid;
    logic [V_W-1:0]    v_quo;
    t_qside            v_side;

    assign v_num = {r_sq_root[SQ_STEPS-1][T_W-1:0], {UV_BITS{1'b0}}};

    rdi_div_pipe #(
        .NUM_W  (VNUM_W),
        .DEN_W  (T_W),
        .QUO_W  (V_W),
        .SIDE_W ($bits(t_qside))
    ) u_vdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sq_v[SQ_STEPS-1]),
        .i_num   (v_num),
        .i_den   (r_radius),
        .i_side  (r_sq_side[SQ_STEPS-1]),
        .o_valid (v_valid),
        .o_quo   (v_quo),
        .o_side  (v_side)
    );

    // ---- result register, misses read as all zero ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.hit     <= v_side.hit;
            r_out.t_hit   <= v_side.hit ? v_side.t : '0;
            r_out.hit_x   <= v_side.hit ? v_side.x : '0;
            r_out.hit_z   <= v_side.hit ? v_side.z : '0;
            r_out.coord_u <= v_side.hit ? v_side.u : '0;
            r_out.coord_v <= (v_side.hit && (r_radius != '0)) ? v_quo : '0;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/rdi_checker.sv =====
`default_nettype none

module rdi_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             i_ready,
    input wire rdi_pkg::t_result i_data
);

    import rdi_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_data))
        else $error("held result changed");

    // a miss carries nothing
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_data.hit |-> (i_data.t_hit == '0) && (i_data.hit_x == '0)
            && (i_data.hit_z == '0) && (i_data.coord_u == '0)
            && (i_data.coord_v == '0))
        else $error("miss with non-zero fields");

    // a hit has positive t and lies inside the disk
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_data.hit |-> (i_data.t_hit != '0) && (i_data.coord_v <= V_ONE))
        else $error("hit out of range");

endmodule

bind ray_disk_intersect_unit rdi_checker u_rdi_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_data  (o_res.data)
);

`default_nettype wire
